FILE: rtl/gvm_pkg.sv
// ----------------------------------------------------------------------------
// gvm_pkg
// Shared constants of the gamepad velocity mapper.
// ----------------------------------------------------------------------------
package gvm_pkg;

  localparam int unsigned OUT_W   = 19;
  localparam int unsigned NOUT    = 6;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_AW  = 3;

  localparam logic [CFG_AW-1:0] CFG_LINEAR_GAIN   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_VERTICAL_GAIN = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_ANGULAR_GAIN  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_BOOST_FACTOR  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_BLEND_WEIGHT  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_HOLD_LIMIT    = 3'd5;

  // output slots
  localparam logic [2:0] OUT_LIN_X = 3'd0;
  localparam logic [2:0] OUT_LIN_Y = 3'd1;
  localparam logic [2:0] OUT_LIN_Z = 3'd2;
  localparam logic [2:0] OUT_ANG_X = 3'd3;
  localparam logic [2:0] OUT_ANG_Y = 3'd4;
  localparam logic [2:0] OUT_ANG_Z = 3'd5;

  localparam logic [16:0] BLEND_ONE = 17'h10000;

endpackage

FILE: rtl/gvm_ram.sv
// ----------------------------------------------------------------------------
// gvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gvm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gamepad_velocity_mapper.sv
// ----------------------------------------------------------------------------
// gamepad_velocity_mapper
// Maps gamepad samples to a smoothed six-axis velocity and gripper command.
// ----------------------------------------------------------------------------
// Input stream s_axis_*: one transfer per gamepad sample. Output stream
// m_axis_*: one transfer per sample carrying the six smoothed velocities,
// gripper event/open and the armed flag. cfg_* writes a configuration register; write
// only while the block is idle.
// Each sample walks the six outputs in turn through four multipliers
// and two small RAMs (hold start times, previous raw values), in five steps
// per output: read, hold update, scale, blend, blend and write back.
// After the last output the result is loaded into the output register from
// the final state. The next sample is taken only once the sequencer is back in
// idle, so a new sample is not accepted while the last one is still computed.
// The output register holds a finished result while the receiver stalls;
// the next sample is still accepted and computed, and waits in the final
// state until the output register is free.
// Reset clears arming and holds, sets the gripper latch to one and loads the
// default register values; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module gamepad_velocity_mapper
  import gvm_pkg::*;
#(
  parameter int unsigned AXIS_BITS  = 16,
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // lsh, lsv, lt, rsh, rsv, rt, left_bumper, right_bumper, gripper_button, now_ms
  input  logic [((6*AXIS_BITS+3+STAMP_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // vel_lin_x/y/z, vel_ang_x/y/z, gripper_event, gripper_open, is_armed
  output logic [((6*19+3+7)/8)*8-1:0] m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned OUT_TW = ((6*19+3+7)/8)*8;
  localparam int unsigned VW     = AXIS_BITS + 1;
  localparam int unsigned PW     = 32 + VW;
  localparam int unsigned SH     = AXIS_BITS - 1 + 14;
  localparam int unsigned ACC_W  = 38;
  localparam int unsigned TRIG_MAG = (4 * (2**(AXIS_BITS-1))) / 5;
  localparam logic signed [VW-1:0] TRIG_LIM = -$signed(VW'(TRIG_MAG));
  localparam logic signed [PW:0]   P_MAX = (PW+1)'(262143);
  localparam logic signed [PW:0]   P_MIN = -(PW+1)'(262144);
  localparam logic signed [ACC_W-1:0] A_MAX = ACC_W'(262143);
  localparam logic signed [ACC_W-1:0] A_MIN = -ACC_W'(262144);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_HOLD = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_BLA  = 3'd4;
  localparam logic [2:0] ST_BLB  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [15:0] lin_gain_q, vert_gain_q, ang_gain_q, boost_q, blend_q, limit_q;

  logic [2:0] state_q, idx_q;
  logic armed_q, lseen_q, rseen_q, have_prev_q, last_grip_q;
  logic [NOUT-1:0] held_q;

  logic signed [AXIS_BITS-1:0] ax_q [6];
  logic lb_q, rb_q, ev_q, open_q;
  logic [STAMP_BITS-1:0] now_q;

  logic [31:0] gb_q;
  logic signed [VW-1:0] val_q;
  logic neg_q, zero_q;
  logic signed [OUT_W-1:0] raw_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [OUT_W-1:0] res_q [NOUT];

  logic m_valid_q;
  logic [OUT_TW-1:0] m_data_q;
  logic load_c;

  logic [STAMP_BITS-1:0] hold_rd;
  logic [OUT_W-1:0] prev_rd;

  // input fields
  logic s_fire;
  logic signed [AXIS_BITS-1:0] in_lt, in_rt;
  logic lseen_d, rseen_d, armed_d, in_grip;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign in_lt  = s_axis_tdata[2*AXIS_BITS +: AXIS_BITS];
  assign in_rt  = s_axis_tdata[5*AXIS_BITS +: AXIS_BITS];
  assign in_grip = s_axis_tdata[6*AXIS_BITS+2];
  assign lseen_d = lseen_q || (!armed_q && (in_lt != '0));
  assign rseen_d = rseen_q || (!armed_q && (in_rt != '0));
  assign armed_d = armed_q || (lseen_d && rseen_d);
  assign load_c  = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  // hold update and operand selection
  logic signed [VW-1:0] cl_l, cl_r, val_c;
  logic [15:0] gain_c;
  logic neg_c, active_c, start_c, held_c, boost_c;
  logic [STAMP_BITS-1:0] diff_c;
  logic [31:0] gb_c;

  always_comb begin
    cl_l = VW'(ax_q[2]);
    cl_r = VW'(ax_q[5]);
    if (cl_l < TRIG_LIM) cl_l = TRIG_LIM;
    if (cl_r < TRIG_LIM) cl_r = TRIG_LIM;
    val_c  = '0;
    gain_c = ang_gain_q;
    neg_c  = 1'b0;
    unique case (idx_q)
      OUT_LIN_X: begin val_c = VW'(ax_q[1]); gain_c = lin_gain_q; neg_c = 1'b1; end
      OUT_LIN_Y: begin val_c = VW'(ax_q[0]); gain_c = lin_gain_q; neg_c = 1'b1; end
      OUT_LIN_Z: begin val_c = cl_l - cl_r; gain_c = vert_gain_q; end
      OUT_ANG_X: val_c = VW'(ax_q[3]);
      OUT_ANG_Y: begin val_c = VW'(ax_q[4]); neg_c = 1'b1; end
      OUT_ANG_Z: val_c = (VW'(signed'({1'b0, lb_q})) - VW'(signed'({1'b0, rb_q})))
                         <<< (AXIS_BITS-1);
      default: ;
    endcase
    // both bumpers pressed keeps the hold running at zero rate
    active_c = (idx_q == OUT_ANG_Z) ? (lb_q || rb_q) : (val_c != '0);
    start_c  = active_c && !held_q[idx_q] && armed_q;
    diff_c   = start_c ? '0 : now_q - hold_rd;
    if (idx_q == OUT_LIN_Z) begin
      held_c  = armed_q;
      boost_c = 1'b0;
    end else begin
      held_c  = active_c && (held_q[idx_q] || start_c);
      boost_c = held_c && (diff_c > STAMP_BITS'(limit_q));
    end
    gb_c = boost_c ? 32'(gain_c) * 32'(boost_q) : 32'(gain_c) << 14;
  end

  // scale
  logic signed [PW:0] prod_c, prodn_c, sh_c;
  logic signed [OUT_W-1:0] raw_c;

  always_comb begin
    prod_c  = $signed({1'b0, gb_q}) * val_q;
    prodn_c = neg_q ? -prod_c : prod_c;
    sh_c    = prodn_c >>> SH;
    if (zero_q)             raw_c = '0;
    else if (sh_c > P_MAX)  raw_c = OUT_W'(P_MAX);
    else if (sh_c < P_MIN)  raw_c = OUT_W'(P_MIN);
    else                    raw_c = OUT_W'(sh_c);
  end

  // blend
  logic [16:0] w_c, wn_c;
  logic signed [ACC_W-1:0] sum_c, bsh_c;
  logic signed [OUT_W-1:0] blend_c;

  always_comb begin
    w_c   = {1'b0, blend_q};
    wn_c  = BLEND_ONE - w_c;
    sum_c = acc_q + $signed({1'b0, wn_c}) * $signed(prev_rd);
    bsh_c = sum_c >>> 16;
    if (!have_prev_q)         blend_c = raw_q;
    else if (bsh_c > A_MAX)   blend_c = OUT_W'(A_MAX);
    else if (bsh_c < A_MIN)   blend_c = OUT_W'(A_MIN);
    else                      blend_c = OUT_W'(bsh_c);
  end

  gvm_ram #(.Width(STAMP_BITS), .Depth(NOUT)) u_hold_ram (
    .clk_i  (clk_i),
    .we_i   ((state_q == ST_HOLD) && start_c && (idx_q != OUT_LIN_Z)),
    .waddr_i(idx_q),
    .wdata_i(now_q),
    .re_i   (state_q == ST_READ),
    .raddr_i(idx_q),
    .rdata_o(hold_rd)
  );

  gvm_ram #(.Width(OUT_W), .Depth(NOUT)) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_BLB),
    .waddr_i(idx_q),
    .wdata_i(raw_q),
    .re_i   (state_q == ST_READ),
    .raddr_i(idx_q),
    .rdata_o(prev_rd)
  );

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q  <= 16'd6554;
      vert_gain_q <= 16'd3277;
      ang_gain_q  <= 16'd13107;
      boost_q     <= 16'd24576;
      blend_q     <= 16'd19661;
      limit_q     <= 16'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_LINEAR_GAIN:   lin_gain_q  <= cfg_data_i;
        CFG_VERTICAL_GAIN: vert_gain_q <= cfg_data_i;
        CFG_ANGULAR_GAIN:  ang_gain_q  <= cfg_data_i;
        CFG_BOOST_FACTOR:  boost_q     <= cfg_data_i;
        CFG_BLEND_WEIGHT:  blend_q     <= cfg_data_i;
        CFG_HOLD_LIMIT:    limit_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      armed_q     <= 1'b0;
      lseen_q     <= 1'b0;
      rseen_q     <= 1'b0;
      have_prev_q <= 1'b0;
      last_grip_q <= 1'b1;
      held_q      <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (load_c) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            lseen_q     <= lseen_d;
            rseen_q     <= rseen_d;
            armed_q     <= armed_d;
            last_grip_q <= in_grip;
            idx_q       <= '0;
            state_q     <= ST_READ;
          end
        end
        ST_READ: state_q <= ST_HOLD;
        ST_HOLD: begin
          if (idx_q != OUT_LIN_Z) held_q[idx_q] <= held_c;
          state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_BLA;
        ST_BLA: state_q <= ST_BLB;
        ST_BLB: begin
          if (idx_q == OUT_ANG_Z) begin
            state_q <= ST_DONE;
          end else begin
            idx_q   <= idx_q + 3'd1;
            state_q <= ST_READ;
          end
        end
        ST_DONE: begin
          if (load_c) begin
            have_prev_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      for (int i = 0; i < 6; i++) begin
        ax_q[i] <= s_axis_tdata[i*AXIS_BITS +: AXIS_BITS];
      end
      lb_q   <= s_axis_tdata[6*AXIS_BITS];
      rb_q   <= s_axis_tdata[6*AXIS_BITS+1];
      now_q  <= s_axis_tdata[6*AXIS_BITS+3 +: STAMP_BITS];
      ev_q   <= (in_grip != last_grip_q);
      open_q <= !in_grip;
    end
    if (state_q == ST_HOLD) begin
      gb_q   <= gb_c;
      val_q  <= val_c;
      neg_q  <= neg_c;
      zero_q <= !held_c;
    end
    if (state_q == ST_MUL) raw_q <= raw_c;
    if (state_q == ST_BLA) acc_q <= $signed({1'b0, w_c}) * raw_q;
    if (state_q == ST_BLB) res_q[idx_q] <= blend_c;
    if (load_c) begin
      m_data_q <= OUT_TW'({armed_q, open_q, ev_q, res_q[5], res_q[4], res_q[3],
                           res_q[2], res_q[1], res_q[0]});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_armed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |=> armed_q) else $error("armed flag dropped");
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= OUT_ANG_Z) else $error("output slot out of range");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && !m_valid_q) |=> m_valid_q && (state_q == ST_IDLE))
    else $error("result not loaded");

endmodule

FILE: sim/tb_gamepad_velocity_mapper.sv
// ----------------------------------------------------------------------------
// tb_gamepad_velocity_mapper
// Self-checking bench: random and directed gamepad samples are streamed in,
// each output transfer is compared with a velocity predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_gamepad_velocity_mapper
  import gvm_pkg::*;
();

  localparam int AXW  = 16;
  localparam int STW  = 32;
  localparam int IN_W = ((6*AXW+3+STW+7)/8)*8;
  localparam int OW   = ((6*19+3+7)/8)*8;

  typedef struct packed {
    logic [31:0] now;
    logic        grip;
    logic        rb;
    logic        lb;
    logic [15:0] rt;
    logic [15:0] rsv;
    logic [15:0] rsh;
    logic [15:0] lt;
    logic [15:0] lsv;
    logic [15:0] lsh;
  } sample_t;

  typedef struct packed {
    logic        armed;
    logic        gopen;
    logic        gevent;
    logic [18:0] az;
    logic [18:0] ay;
    logic [18:0] ax;
    logic [18:0] lz;
    logic [18:0] ly;
    logic [18:0] lx;
  } velocity_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  gamepad_velocity_mapper u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  longint gain_lin, gain_vert, gain_ang, boost, blend, hold_lim;
  bit armed, l_seen, r_seen, have_prev, last_grip;
  bit held [5];
  longint hold_t0 [5];
  longint prev_raw [6];

  sample_t   pending_samples[$];
  velocity_t expected_vel[$];
  int errors = 0;
  int gap_left = 0;
  int burst_left = 0;
  bit in_fired = 1'b0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat19(longint v);
    if (v > 262143) return 262143;
    if (v < -262144) return -262144;
    return v;
  endfunction

  function automatic int hold_update(int ch, bit act, longint now);
    if (act && !held[ch] && armed) begin
      hold_t0[ch] = now;
      held[ch] = 1'b1;
    end else if (!act) begin
      held[ch] = 1'b0;
    end
    if (!held[ch]) return 0;
    return (((now - hold_t0[ch]) & 64'hFFFF_FFFF) > hold_lim) ? 2 : 1;
  endfunction

  function automatic longint scale_axis(longint g, longint v, int frac, int mode, bit neg);
    longint p;
    int s;
    s = frac;
    if (mode == 0) return 0;
    p = g * v;
    if (mode == 2) begin
      p = p * boost;
      s += 14;
    end
    if (neg) p = -p;
    return sat19(fshift(p, s));
  endfunction

  function automatic longint trig_clamp(longint t);
    longint lim;
    lim = longint'(-((4 << 15) / 5));
    return (t < lim) ? lim : t;
  endfunction

  function automatic velocity_t predict_velocity(sample_t s);
    velocity_t r;
    longint lh, lv, lt, rh, rv, rt, now, v;
    longint raw [6];
    int mode;
    lh = longint'($signed(s.lsh)); lv = longint'($signed(s.lsv));
    lt = longint'($signed(s.lt));  rh = longint'($signed(s.rsh));
    rv = longint'($signed(s.rsv)); rt = longint'($signed(s.rt));
    now = longint'(s.now);
    if (!armed) begin
      if (lt != 0) l_seen = 1'b1;
      if (rt != 0) r_seen = 1'b1;
      if (l_seen && r_seen) armed = 1'b1;
    end
    mode = hold_update(1, lv != 0, now);
    raw[0] = scale_axis(gain_lin, lv, 15, mode, 1'b1);
    mode = hold_update(0, lh != 0, now);
    raw[1] = scale_axis(gain_lin, lh, 15, mode, 1'b1);
    raw[2] = armed ? sat19(fshift(gain_vert * (trig_clamp(lt) - trig_clamp(rt)), 15)) : 0;
    mode = hold_update(3, rh != 0, now);
    raw[3] = scale_axis(gain_ang, rh, 15, mode, 1'b0);
    mode = hold_update(4, rv != 0, now);
    raw[4] = scale_axis(gain_ang, rv, 15, mode, 1'b1);
    mode = hold_update(2, s.lb || s.rb, now);
    raw[5] = scale_axis(gain_ang, longint'(s.lb) - longint'(s.rb), 0, mode, 1'b0);
    for (int i = 0; i < 6; i++) begin
      v = raw[i];
      if (have_prev) v = fshift(blend * raw[i] + (65536 - blend) * prev_raw[i], 16);
      v = sat19(v);
      case (i)
        0: r.lx = v[18:0];
        1: r.ly = v[18:0];
        2: r.lz = v[18:0];
        3: r.ax = v[18:0];
        4: r.ay = v[18:0];
        default: r.az = v[18:0];
      endcase
      prev_raw[i] = raw[i];
    end
    have_prev = 1'b1;
    r.gevent = (s.grip != last_grip);
    last_grip = s.grip;
    r.gopen = !s.grip;
    r.armed = armed;
    return r;
  endfunction

  // sender: bursts and gaps; an offered sample stays until its transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_fired) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        s_axis_tdata <= IN_W'(pending_samples[0]);
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 80);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_fired <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_vel.push_back(predict_velocity(sample_t'(s_axis_tdata[$bits(sample_t)-1:0])));
      void'(pending_samples.pop_front());
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if ((stall_phase / 500) % 3 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) < 40 + 20 * ((stall_phase / 500) % 3));
  end

  always @(posedge clk_i) begin
    velocity_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = velocity_t'(m_axis_tdata[$bits(velocity_t)-1:0]);
      if (expected_vel.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_vel.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || s_axis_tvalid || expected_vel.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LINEAR_GAIN:   gain_lin = longint'(val);
      CFG_VERTICAL_GAIN: gain_vert = longint'(val);
      CFG_ANGULAR_GAIN:  gain_ang = longint'(val);
      CFG_BOOST_FACTOR:  boost = longint'(val);
      CFG_BLEND_WEIGHT:  blend = longint'(val);
      default:           hold_lim = longint'(val);
    endcase
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 7))
      0, 1: return 16'h0000;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'(-$urandom_range(26214, 32768));
      default: return 16'($urandom);
    endcase
  endfunction

  longint clock_ms = 0;
  function automatic sample_t rand_sample();
    sample_t s;
    s.lsh = rand_axis(); s.lsv = rand_axis(); s.lt = rand_axis();
    s.rsh = rand_axis(); s.rsv = rand_axis(); s.rt = rand_axis();
    s.lb = 1'($urandom_range(0, 1)); s.rb = 1'($urandom_range(0, 1));
    s.grip = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 19))
      0: clock_ms = longint'($urandom);
      1: clock_ms = clock_ms - longint'($urandom_range(1, 5000));
      default: clock_ms = clock_ms + longint'($urandom_range(0, 400));
    endcase
    s.now = clock_ms[31:0];
    return s;
  endfunction

  initial begin
    sample_t s;
    gain_lin = 6554; gain_vert = 3277; gain_ang = 13107;
    boost = 24576; blend = 19661; hold_lim = 1000;
    armed = 0; l_seen = 0; r_seen = 0; have_prev = 0; last_grip = 1;
    for (int i = 0; i < 5; i++) begin held[i] = 0; hold_t0[i] = 0; end
    for (int i = 0; i < 6; i++) prev_raw[i] = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: unarmed sticks, one trigger, then arming, extremes and holds
    s = '0; s.lsh = 16'h7FFF; s.lsv = 16'h8000; s.grip = 1; s.now = 32'd0;
    pending_samples.push_back(s);
    s.lt = 16'h8000; s.now = 32'd10; pending_samples.push_back(s);
    s.rt = 16'h7FFF; s.lt = 16'h0000; s.now = 32'd20; pending_samples.push_back(s);
    s = '0; s.lt = 16'h8000; s.rt = 16'h8000; s.lsh = 16'h8000; s.lsv = 16'h7FFF;
    s.rsh = 16'h8000; s.rsv = 16'h7FFF; s.lb = 1; s.now = 32'd30;
    pending_samples.push_back(s);
    s.now = 32'd1030; pending_samples.push_back(s);
    s.now = 32'd1031; s.rb = 1; pending_samples.push_back(s);
    s.lb = 0; s.now = 32'd1500; s.grip = 0; pending_samples.push_back(s);
    s = '0; s.now = 32'hFFFF_FFF0; s.lsh = 16'h0001; s.grip = 1;
    pending_samples.push_back(s);
    s.now = 32'd2000; pending_samples.push_back(s);
    s.now = 32'h0000_0005; s.lt = 16'h7FFF; s.rt = 16'h9999; pending_samples.push_back(s);
    wait_drained();

    // random phases over register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 1) begin
        write_reg(CFG_LINEAR_GAIN, 16'hFFFF); write_reg(CFG_VERTICAL_GAIN, 16'hFFFF);
        write_reg(CFG_ANGULAR_GAIN, 16'hFFFF); write_reg(CFG_BOOST_FACTOR, 16'hFFFF);
        write_reg(CFG_BLEND_WEIGHT, 16'hFFFF); write_reg(CFG_HOLD_LIMIT, 16'hFFFF);
      end else if (ph == 2) begin
        write_reg(CFG_LINEAR_GAIN, 16'h0000); write_reg(CFG_VERTICAL_GAIN, 16'h0000);
        write_reg(CFG_ANGULAR_GAIN, 16'h0000); write_reg(CFG_BOOST_FACTOR, 16'h0000);
        write_reg(CFG_BLEND_WEIGHT, 16'h0000); write_reg(CFG_HOLD_LIMIT, 16'h0000);
      end else if (ph > 2) begin
        write_reg(CFG_LINEAR_GAIN, 16'($urandom)); write_reg(CFG_VERTICAL_GAIN, 16'($urandom));
        write_reg(CFG_ANGULAR_GAIN, 16'($urandom)); write_reg(CFG_BOOST_FACTOR, 16'($urandom));
        write_reg(CFG_BLEND_WEIGHT, 16'($urandom));
        write_reg(CFG_HOLD_LIMIT, 16'($urandom_range(0, 1500)));
      end
      for (int n = 0; n < 210; n++) pending_samples.push_back(rand_sample());
      wait_drained();
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
